// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the positional list engine.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/ple_pkg.sv
// Types and constants for the positional list engine.
// No dependencies; used by positional_list_engine.
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int ELEM_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int ACT_W    = 3;
   localparam int POS_W    = 5;
   localparam int POSB_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int STAT_W   = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT  = 3'd0,
      ACT_REMOVE  = 3'd1,
      ACT_GET     = 3'd2,
      ACT_SET     = 3'd3,
      ACT_SWAP    = 3'd4,
      ACT_REVERSE = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET,
      ST_SHIFT_UP,
      ST_INSERT_LAST,
      ST_SHIFT_DOWN,
      ST_PAIR_A,
      ST_PAIR_B,
      ST_PAIR_C
   } state_type;

endpackage

// File: hw/rtl/positional_list_engine.sv
// Positional list engine: bounded ordered list held in one element memory.
// Depends on ple_pkg and assert_macros.svh.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-------------------------------------------
//   request   | start / busy        | req_action, req_position, req_position_b,
//             |                     | req_value
//   response  | rsp_strobe (1 cyc)  | rsp_read_value, rsp_element_count,
//             |                     | rsp_status
//
// Errors, set, append, remove of the last element, swap of an index with
// itself, short reverse and unused codes finish in the accept cycle; get
// adds ST_GET. Insert runs ST_SHIFT_UP then ST_INSERT_LAST, remove runs
// ST_SHIFT_DOWN, swap and reverse run ST_PAIR_A then ST_PAIR_B/ST_PAIR_C per
// pair. The element memory has a single read port: one element moves per cycle.
// The response shows in the cycle after its final state; busy drops then.
// Reset clears the count and control; the element memory is not cleared.
// The receiver cannot stall; each response is taken in its strobe cycle.
`include "assert_macros.svh"

module positional_list_engine
   import ple_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ACT_W-1:0]   req_action,
   input  logic [POS_W-1:0]   req_position,
   input  logic [POSB_W-1:0]  req_position_b,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_strobe,
   output logic [VALUE_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]   rsp_element_count,
   output logic [STAT_W-1:0]  rsp_status
);

   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // element memory
   logic [ELEM_W-1:0] mem [CAPACITY];
   logic [ELEM_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ELEM_W-1:0] wr_data;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [ELEM_W-1:0] hold_ff, hold_in;
   logic              rev_ff, rev_in;

   logic               rsp_strobe_ff;
   logic [VALUE_W-1:0] rsp_read_value_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   status_type         rsp_status_ff;

   logic              accept;
   logic              finish;
   status_type        fin_status;
   logic [ELEM_W-1:0] fin_value;

   // request decode
   action_type        act;
   logic [CMP_W-1:0]  pos_x, posb_x, cnt_x;
   logic [IDX_W-1:0]  pos_idx;
   state_type         dec_next;
   status_type        dec_status;
   logic [CNT_W-1:0]  dec_count;
   logic              dec_rd, dec_wr, dec_rev;
   logic [IDX_W-1:0]  dec_rd_addr, dec_lo, dec_hi;

   logic              more_up, more_dn, pair_more;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign more_up   = (IDX_W'(hi_ff - IDX_W'(1)) > lo_ff);
   assign more_dn   = ((CNT_W'(lo_ff) + CNT_W'(2)) < count_ff);
   assign pair_more = rev_ff && ((CNT_W'(lo_ff) + CNT_W'(2)) < CNT_W'(hi_ff));

   always_comb begin
      act         = action_type'(req_action);
      pos_x       = CMP_W'(req_position);
      posb_x      = CMP_W'(req_position_b);
      cnt_x       = CMP_W'(count_ff);
      pos_idx     = req_position[IDX_W-1:0];
      dec_next    = ST_IDLE;
      dec_status  = STAT_OK;
      dec_count   = count_ff;
      dec_rd      = 1'b0;
      dec_wr      = 1'b0;
      dec_rev     = 1'b0;
      dec_rd_addr = pos_idx;
      dec_lo      = pos_idx;
      dec_hi      = pos_idx;
      case (act)
         ACT_INSERT: begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               dec_status = STAT_FULL;
            end else if (pos_x > cnt_x) begin
               dec_status = STAT_RANGE;
            end else if (pos_x == cnt_x) begin
               dec_wr    = 1'b1;
               dec_count = count_ff + CNT_W'(1);
            end else begin
               // move the tail up, starting from the last element
               dec_rd      = 1'b1;
               dec_rd_addr = IDX_W'(count_ff - CNT_W'(1));
               dec_hi      = IDX_W'(count_ff);
               dec_next    = ST_SHIFT_UP;
            end
         end
         ACT_REMOVE: begin
            if (pos_x >= cnt_x) begin
               dec_status = STAT_RANGE;
            end else if ((pos_x + CMP_W'(1)) == cnt_x) begin
               dec_count = count_ff - CNT_W'(1);
            end else begin
               dec_rd      = 1'b1;
               dec_rd_addr = pos_idx + IDX_W'(1);
               dec_next    = ST_SHIFT_DOWN;
            end
         end
         ACT_GET: begin
            if (pos_x >= cnt_x) begin
               dec_status = STAT_RANGE;
            end else begin
               dec_rd   = 1'b1;
               dec_next = ST_GET;
            end
         end
         ACT_SET: begin
            if (pos_x >= cnt_x) begin
               dec_status = STAT_RANGE;
            end else begin
               dec_wr = 1'b1;
            end
         end
         ACT_SWAP: begin
            if ((pos_x >= cnt_x) || (posb_x >= cnt_x)) begin
               dec_status = STAT_RANGE;
            end else if (pos_idx != IDX_W'(req_position_b)) begin
               dec_rd   = 1'b1;
               dec_hi   = IDX_W'(req_position_b);
               dec_next = ST_PAIR_A;
            end
         end
         ACT_REVERSE: begin
            if (cnt_x >= CMP_W'(2)) begin
               dec_rd      = 1'b1;
               dec_rd_addr = '0;
               dec_lo      = '0;
               dec_hi      = IDX_W'(count_ff - CNT_W'(1));
               dec_rev     = 1'b1;
               dec_next    = ST_PAIR_A;
            end
         end
         default: begin
            dec_status = STAT_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        state_in = accept ? dec_next : ST_IDLE;
         ST_GET:         state_in = ST_IDLE;
         ST_SHIFT_UP:    state_in = more_up ? ST_SHIFT_UP : ST_INSERT_LAST;
         ST_INSERT_LAST: state_in = ST_IDLE;
         ST_SHIFT_DOWN:  state_in = more_dn ? ST_SHIFT_DOWN : ST_IDLE;
         ST_PAIR_A:      state_in = ST_PAIR_B;
         ST_PAIR_B:      state_in = ST_PAIR_C;
         ST_PAIR_C:      state_in = pair_more ? ST_PAIR_B : ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // memory control and datapath
   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = lo_ff;
      wr_en      = 1'b0;
      wr_addr    = lo_ff;
      wr_data    = rd_data_ff;
      finish     = 1'b0;
      fin_status = STAT_OK;
      fin_value  = '0;
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      hold_in    = hold_ff;
      rev_in     = rev_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_en   = dec_rd;
               rd_addr = dec_rd_addr;
               wr_en   = dec_wr;
               wr_addr = pos_idx;
               wr_data = ELEM_W'(req_value);
               lo_in   = dec_lo;
               hi_in   = dec_hi;
               rev_in  = dec_rev;
               hold_in = ELEM_W'(req_value);
               if (dec_next == ST_IDLE) begin
                  finish     = 1'b1;
                  fin_status = dec_status;
                  count_in   = dec_count;
               end
            end
         end
         ST_GET: begin
            finish    = 1'b1;
            fin_value = rd_data_ff;
         end
         ST_SHIFT_UP: begin
            // hi_ff is the destination of the element arriving now
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            if (more_up) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(hi_ff - IDX_W'(2));
               hi_in   = IDX_W'(hi_ff - IDX_W'(1));
            end
         end
         ST_INSERT_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = hold_ff;
            finish   = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         ST_SHIFT_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            if (more_dn) begin
               rd_en   = 1'b1;
               rd_addr = lo_ff + IDX_W'(2);
               lo_in   = lo_ff + IDX_W'(1);
            end else begin
               finish   = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ST_PAIR_A: begin
            // low element arrives; fetch the high one
            hold_in = rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = hi_ff;
         end
         ST_PAIR_B: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            if (pair_more) begin
               rd_en   = 1'b1;
               rd_addr = lo_ff + IDX_W'(1);
            end
         end
         ST_PAIR_C: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = hold_ff;
            if (pair_more) begin
               hold_in = rd_data_ff;
               rd_en   = 1'b1;
               rd_addr = hi_ff - IDX_W'(1);
               lo_in   = lo_ff + IDX_W'(1);
               hi_in   = hi_ff - IDX_W'(1);
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      hold_ff <= hold_in;
      rev_ff  <= rev_in;
      if (finish) begin
         rsp_read_value_ff <= VALUE_W'(fin_value);
         rsp_count_ff      <= count_in;
         rsp_status_ff     <= fin_status;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_value    = rsp_read_value_ff;
   assign rsp_element_count = POS_W'(rsp_count_ff);
   assign rsp_status        = rsp_status_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_quick_response, clock, reset, accept && (dec_next == ST_IDLE), rsp_strobe_ff)
   `ASSERT_IMPLY(a_no_same_entry, clock, reset, busy && rd_en && wr_en, rd_addr != wr_addr)
   `ASSERT_IMPLY(a_full_only_at_cap, clock, reset, rsp_strobe_ff && (rsp_status_ff == STAT_FULL), rsp_count_ff == CNT_W'(CAPACITY))

endmodule
